[rtl/core/srts_pkg.sv]
// Shared types and codes for the sparse row term store.
package srts_pkg;

  // Operation codes carried on the kind field.
  typedef enum logic [1:0] {
    KIND_SET_START = 2'd0,
    KIND_APPEND    = 2'd1,
    KIND_REMOVE    = 2'd2,
    KIND_READ      = 2'd3
  } kind_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Fixed field widths of the command and result ports.
  localparam int unsigned RowPortW   = 10;
  localparam int unsigned SlotW      = 12;
  localparam int unsigned TermPortW  = 12;
  localparam int unsigned ColW       = 12;
  localparam int unsigned CountPortW = 13;
  localparam int unsigned CoefPortW  = 64;

  // Access request for the row memory.
  typedef struct packed {
    logic en;
    logic we;
  } row_req_t;

  // Per-field write enables of the term memory.
  typedef struct packed {
    logic coef;
    logic col;
    logic s2t;
    logic t2s;
  } term_we_t;

endpackage

[rtl/core/sparse_row_term_store_unit.sv]
// Top level of the sparse row term store.
//
// Commands enter on start_i with kind_i, row_i and the operand fields; a
// command transfer happens at a clock edge where start_i is high and busy_o
// is low. Each command yields exactly one result, shown on the result ports
// for a single cycle with done_o high; the receiver cannot stall it.
// Commands run one at a time through a sequencer that owns one port of the
// row memory (start slot and live count) and one port of the term memory
// (coefficient, column, inverse map and forward map).
// After its row entry is read, a command runs through dependent accesses
// on the single term memory port: set row start, and any command that fails
// its first range check or removes from an empty row, end there; append
// writes the term and then its forward map; read entry reads the term;
// remove term reads the hole slot, then the row's last entry, moves that
// entry into the hole and writes its forward map, or stops if the looked-up
// slots are out of range. busy_o falls in the cycle the result is shown, so
// the next command may transfer then, and not before. After reset a clearing
// pass zeroes every row entry, one row a cycle, holding busy_o high.
module sparse_row_term_store_unit #(
  parameter int unsigned MAX_ROWS  = 1024,
  parameter int unsigned MAX_TERMS = 4096,
  parameter int unsigned COEF_BITS = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [1:0]                          kind_i,
  input  logic [srts_pkg::RowPortW-1:0]       row_i,
  input  logic [srts_pkg::SlotW-1:0]          row_start_i,
  input  logic [srts_pkg::TermPortW-1:0]      term_index_i,
  input  logic [srts_pkg::CoefPortW-1:0]      coefficient_i,
  input  logic [srts_pkg::ColW-1:0]           column_i,
  input  logic [srts_pkg::SlotW-1:0]          position_i,
  output logic                                done_o,
  output logic [srts_pkg::SlotW-1:0]          slot_o,
  output logic [srts_pkg::CountPortW-1:0]     row_count_after_o,
  output logic [srts_pkg::TermPortW-1:0]      moved_term_o,
  output logic [srts_pkg::CoefPortW-1:0]      coefficient_out_o,
  output logic [srts_pkg::ColW-1:0]           column_out_o,
  output logic [1:0]                          status_o
);

  localparam int unsigned RowIdxW  = $clog2(MAX_ROWS);
  localparam int unsigned TermIdxW = $clog2(MAX_TERMS);
  localparam int unsigned CntW     = $clog2(MAX_TERMS + 1);
  localparam int unsigned RowDataW = srts_pkg::SlotW + CntW;

  srts_pkg::row_req_t             row_req;
  logic [RowIdxW-1:0]             row_addr;
  logic [RowDataW-1:0]            row_wdata;
  logic [RowDataW-1:0]            row_rdata;

  logic                           term_en;
  srts_pkg::term_we_t             term_we;
  logic [TermIdxW-1:0]            term_addr;
  logic [COEF_BITS-1:0]           term_coef_w, term_coef_r;
  logic [srts_pkg::ColW-1:0]      term_col_w, term_col_r;
  logic [TermIdxW-1:0]            term_s2t_w, term_s2t_r;
  logic [TermIdxW-1:0]            term_t2s_w, term_t2s_r;

  // Command sequencer.
  srts_ctrl #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_TERMS (MAX_TERMS),
    .COEF_BITS (COEF_BITS),
    .RowIdxW   (RowIdxW),
    .TermIdxW  (TermIdxW),
    .CntW      (CntW)
  ) u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .kind_i            (kind_i),
    .row_i             (row_i),
    .row_start_i       (row_start_i),
    .term_index_i      (term_index_i),
    .coefficient_i     (coefficient_i),
    .column_i          (column_i),
    .position_i        (position_i),
    .done_o            (done_o),
    .slot_o            (slot_o),
    .row_count_after_o (row_count_after_o),
    .moved_term_o      (moved_term_o),
    .coefficient_out_o (coefficient_out_o),
    .column_out_o      (column_out_o),
    .status_o          (status_o),
    .row_req_o         (row_req),
    .row_addr_o        (row_addr),
    .row_wdata_o       (row_wdata),
    .row_rdata_i       (row_rdata),
    .term_en_o         (term_en),
    .term_we_o         (term_we),
    .term_addr_o       (term_addr),
    .term_coef_o       (term_coef_w),
    .term_col_o        (term_col_w),
    .term_s2t_o        (term_s2t_w),
    .term_t2s_o        (term_t2s_w),
    .term_coef_i       (term_coef_r),
    .term_col_i        (term_col_r),
    .term_s2t_i        (term_s2t_r),
    .term_t2s_i        (term_t2s_r)
  );

  // Row start and live count store.
  srts_row_mem #(
    .DEPTH (MAX_ROWS),
    .AW    (RowIdxW),
    .DW    (RowDataW)
  ) u_row_mem (
    .clk_i   (clk_i),
    .req_i   (row_req),
    .addr_i  (row_addr),
    .wdata_i (row_wdata),
    .rdata_o (row_rdata)
  );

  // Term store with both maps.
  srts_term_mem #(
    .DEPTH  (MAX_TERMS),
    .AW     (TermIdxW),
    .COEF_W (COEF_BITS)
  ) u_term_mem (
    .clk_i  (clk_i),
    .en_i   (term_en),
    .we_i   (term_we),
    .addr_i (term_addr),
    .coef_i (term_coef_w),
    .col_i  (term_col_w),
    .s2t_i  (term_s2t_w),
    .t2s_i  (term_t2s_w),
    .coef_o (term_coef_r),
    .col_o  (term_col_r),
    .s2t_o  (term_s2t_r),
    .t2s_o  (term_t2s_r)
  );

endmodule

[rtl/core/srts_row_mem.sv]
// Row memory: start slot and live term count of every row.
module srts_row_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned DW    = 25
) (
  input  logic                    clk_i,
  input  srts_pkg::row_req_t      req_i,
  input  logic [AW-1:0]           addr_i,
  input  logic [DW-1:0]           wdata_i,
  output logic [DW-1:0]           rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  // Single port: a write or a registered read in each cycle.
  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      if (req_i.we) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/srts_term_mem.sv]
// Term memory: coefficient, column and inverse map per slot, forward map per term.
module srts_term_mem #(
  parameter int unsigned DEPTH  = 4096,
  parameter int unsigned AW     = 12,
  parameter int unsigned COEF_W = 64
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  srts_pkg::term_we_t       we_i,
  input  logic [AW-1:0]            addr_i,
  input  logic [COEF_W-1:0]        coef_i,
  input  logic [srts_pkg::ColW-1:0] col_i,
  input  logic [AW-1:0]            s2t_i,
  input  logic [AW-1:0]            t2s_i,
  output logic [COEF_W-1:0]        coef_o,
  output logic [srts_pkg::ColW-1:0] col_o,
  output logic [AW-1:0]            s2t_o,
  output logic [AW-1:0]            t2s_o
);

  logic [COEF_W-1:0]         coef_mem [DEPTH];
  logic [srts_pkg::ColW-1:0] col_mem  [DEPTH];
  logic [AW-1:0]             s2t_mem  [DEPTH];
  logic [AW-1:0]             t2s_mem  [DEPTH];

  logic [COEF_W-1:0]         coef_q;
  logic [srts_pkg::ColW-1:0] col_q;
  logic [AW-1:0]             s2t_q;
  logic [AW-1:0]             t2s_q;

  // One address per cycle; fields are written under their own enables,
  // and a cycle with no enable set is a registered read of the whole entry.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i == '0) begin
        coef_q <= coef_mem[addr_i];
        col_q  <= col_mem[addr_i];
        s2t_q  <= s2t_mem[addr_i];
        t2s_q  <= t2s_mem[addr_i];
      end else begin
        if (we_i.coef) coef_mem[addr_i] <= coef_i;
        if (we_i.col)  col_mem[addr_i]  <= col_i;
        if (we_i.s2t)  s2t_mem[addr_i]  <= s2t_i;
        if (we_i.t2s)  t2s_mem[addr_i]  <= t2s_i;
      end
    end
  end

  assign coef_o = coef_q;
  assign col_o  = col_q;
  assign s2t_o  = s2t_q;
  assign t2s_o  = t2s_q;

endmodule

[rtl/core/srts_ctrl.sv]
// Operation sequencer: reads, checks and writes back the row and term memories.
module srts_ctrl #(
  parameter int unsigned MAX_ROWS  = 1024,
  parameter int unsigned MAX_TERMS = 4096,
  parameter int unsigned COEF_BITS = 64,
  parameter int unsigned RowIdxW   = 10,
  parameter int unsigned TermIdxW  = 12,
  parameter int unsigned CntW      = 13
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Command channel
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [1:0]                          kind_i,
  input  logic [srts_pkg::RowPortW-1:0]       row_i,
  input  logic [srts_pkg::SlotW-1:0]          row_start_i,
  input  logic [srts_pkg::TermPortW-1:0]      term_index_i,
  input  logic [srts_pkg::CoefPortW-1:0]      coefficient_i,
  input  logic [srts_pkg::ColW-1:0]           column_i,
  input  logic [srts_pkg::SlotW-1:0]          position_i,
  // Result channel
  output logic                                done_o,
  output logic [srts_pkg::SlotW-1:0]          slot_o,
  output logic [srts_pkg::CountPortW-1:0]     row_count_after_o,
  output logic [srts_pkg::TermPortW-1:0]      moved_term_o,
  output logic [srts_pkg::CoefPortW-1:0]      coefficient_out_o,
  output logic [srts_pkg::ColW-1:0]           column_out_o,
  output logic [1:0]                          status_o,
  // Row memory port
  output srts_pkg::row_req_t                  row_req_o,
  output logic [RowIdxW-1:0]                  row_addr_o,
  output logic [srts_pkg::SlotW+CntW-1:0]     row_wdata_o,
  input  logic [srts_pkg::SlotW+CntW-1:0]     row_rdata_i,
  // Term memory port
  output logic                                term_en_o,
  output srts_pkg::term_we_t                  term_we_o,
  output logic [TermIdxW-1:0]                 term_addr_o,
  output logic [COEF_BITS-1:0]                term_coef_o,
  output logic [srts_pkg::ColW-1:0]           term_col_o,
  output logic [TermIdxW-1:0]                 term_s2t_o,
  output logic [TermIdxW-1:0]                 term_t2s_o,
  input  logic [COEF_BITS-1:0]                term_coef_i,
  input  logic [srts_pkg::ColW-1:0]           term_col_i,
  input  logic [TermIdxW-1:0]                 term_s2t_i,
  input  logic [TermIdxW-1:0]                 term_t2s_i
);

  localparam int unsigned SlotW    = srts_pkg::SlotW;
  localparam int unsigned SumW     = ((CntW > SlotW) ? CntW : SlotW) + 1;
  localparam int unsigned RowCmpW  = ($clog2(MAX_ROWS + 1) > srts_pkg::RowPortW) ?
                                     $clog2(MAX_ROWS + 1) : srts_pkg::RowPortW;
  localparam int unsigned CntExtW  = (CntW > srts_pkg::CountPortW) ? CntW
                                                                   : srts_pkg::CountPortW;
  localparam int unsigned TermExtW = (TermIdxW > srts_pkg::TermPortW) ? TermIdxW
                                                                      : srts_pkg::TermPortW;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ROW,
    S_APP_MAP,
    S_RM_HOLE,
    S_RM_LAST,
    S_RM_MAP,
    S_READ
  } ctrl_state_e;

  // Count to the 13-bit result field.
  function automatic logic [srts_pkg::CountPortW-1:0] cnt_out(input logic [CntW-1:0] c);
    logic [CntExtW-1:0] e;
    e = CntExtW'(c);
    return e[srts_pkg::CountPortW-1:0];
  endfunction

  // Term index to the 12-bit result field.
  function automatic logic [srts_pkg::TermPortW-1:0] term_out(input logic [TermIdxW-1:0] t);
    logic [TermExtW-1:0] e;
    e = TermExtW'(t);
    return e[srts_pkg::TermPortW-1:0];
  endfunction

  ctrl_state_e                      state_q, state_d;
  logic [RowIdxW-1:0]               clr_q, clr_d;
  srts_pkg::kind_e                  kind_q, kind_d;
  logic                             row_ok_q, row_ok_d;
  logic [RowIdxW-1:0]               row_q, row_d;
  logic [SlotW-1:0]                 start_q, start_d;
  logic [srts_pkg::TermPortW-1:0]   term_q, term_d;
  logic [COEF_BITS-1:0]             coef_q, coef_d;
  logic [srts_pkg::ColW-1:0]        col_q, col_d;
  logic [SlotW-1:0]                 pos_q, pos_d;
  logic [SumW-1:0]                  slot_q, slot_d;
  logic [CntW-1:0]                  cnt_q, cnt_d;
  logic [TermIdxW-1:0]              hole_q, hole_d;
  logic [TermIdxW-1:0]              mv_q, mv_d;

  logic                             done_q, done_d;
  logic [SlotW-1:0]                 res_slot_q, res_slot_d;
  logic [srts_pkg::CountPortW-1:0]  res_cnt_q, res_cnt_d;
  logic [srts_pkg::TermPortW-1:0]   res_moved_q, res_moved_d;
  logic [srts_pkg::CoefPortW-1:0]   res_coef_q, res_coef_d;
  logic [srts_pkg::ColW-1:0]        res_col_q, res_col_d;
  srts_pkg::status_e                res_status_q, res_status_d;

  logic [RowCmpW-1:0]               row_ext;
  logic [SlotW-1:0]                 base;
  logic [CntW-1:0]                  cnt;
  logic [SumW-1:0]                  lim;
  logic [SumW-1:0]                  sum_app;
  logic [SumW-1:0]                  sum_rd;
  logic [SumW-1:0]                  sum_last;
  logic                             term_ok;
  logic [TermExtW-1:0]              term_ext;
  logic [TermIdxW-1:0]              term_idx;

  // Fields of the row entry just read, and the slot arithmetic on them.
  assign row_ext  = RowCmpW'(row_i);
  assign base     = row_rdata_i[CntW +: SlotW];
  assign cnt      = row_rdata_i[CntW-1:0];
  assign lim      = SumW'(MAX_TERMS);
  assign sum_app  = SumW'(base) + SumW'(cnt);
  assign sum_rd   = SumW'(base) + SumW'(pos_q);
  assign sum_last = sum_app - SumW'(1);
  assign term_ok  = SumW'(term_q) < lim;
  assign term_ext = TermExtW'(term_q);
  assign term_idx = term_ext[TermIdxW-1:0];

  // Next state, memory accesses and result values.
  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    kind_d       = kind_q;
    row_ok_d     = row_ok_q;
    row_d        = row_q;
    start_d      = start_q;
    term_d       = term_q;
    coef_d       = coef_q;
    col_d        = col_q;
    pos_d        = pos_q;
    slot_d       = slot_q;
    cnt_d        = cnt_q;
    hole_d       = hole_q;
    mv_d         = mv_q;
    done_d       = 1'b0;
    res_slot_d   = res_slot_q;
    res_cnt_d    = res_cnt_q;
    res_moved_d  = res_moved_q;
    res_coef_d   = res_coef_q;
    res_col_d    = res_col_q;
    res_status_d = res_status_q;

    row_req_o    = '0;
    row_addr_o   = row_q;
    row_wdata_o  = '0;
    term_en_o    = 1'b0;
    term_we_o    = '0;
    term_addr_o  = term_idx;
    term_coef_o  = coef_q;
    term_col_o   = col_q;
    term_s2t_o   = term_idx;
    term_t2s_o   = slot_q[TermIdxW-1:0];

    unique case (state_q)
      // Clearing pass: zero every row entry, one a cycle.
      S_CLEAR: begin
        row_req_o  = '{en: 1'b1, we: 1'b1};
        row_addr_o = clr_q;
        clr_d      = clr_q + RowIdxW'(1);
        if (clr_q == RowIdxW'(MAX_ROWS - 1)) begin
          state_d = S_IDLE;
        end
      end

      // Take a command and start reading its row.
      S_IDLE: begin
        row_addr_o = row_ext[RowIdxW-1:0];
        if (start_i) begin
          row_req_o = '{en: 1'b1, we: 1'b0};
          kind_d    = srts_pkg::kind_e'(kind_i);
          row_ok_d  = row_ext < RowCmpW'(MAX_ROWS);
          row_d     = row_ext[RowIdxW-1:0];
          start_d   = row_start_i;
          term_d    = term_index_i;
          coef_d    = coefficient_i[COEF_BITS-1:0];
          col_d     = column_i;
          pos_d     = position_i;
          state_d   = S_ROW;
        end
      end

      // Row entry is available: decide the operation.
      S_ROW: begin
        res_moved_d  = '0;
        res_coef_d   = '0;
        res_col_d    = '0;
        res_status_d = srts_pkg::ST_OK;
        res_cnt_d    = cnt_out(cnt);
        if (!row_ok_q) begin
          done_d       = 1'b1;
          res_slot_d   = '0;
          res_cnt_d    = '0;
          res_status_d = srts_pkg::ST_RANGE;
          state_d      = S_IDLE;
        end else begin
          unique case (kind_q)
            srts_pkg::KIND_SET_START: begin
              row_req_o   = '{en: 1'b1, we: 1'b1};
              row_wdata_o = {start_q, {CntW{1'b0}}};
              done_d      = 1'b1;
              res_slot_d  = start_q;
              res_cnt_d   = '0;
              state_d     = S_IDLE;
            end
            srts_pkg::KIND_APPEND: begin
              res_slot_d = sum_app[SlotW-1:0];
              if (sum_app >= lim || !term_ok) begin
                done_d       = 1'b1;
                res_status_d = srts_pkg::ST_RANGE;
                state_d      = S_IDLE;
              end else begin
                // Store the term at the row's end and bump the count.
                term_en_o   = 1'b1;
                term_we_o   = '{coef: 1'b1, col: 1'b1, s2t: 1'b1, t2s: 1'b0};
                term_addr_o = sum_app[TermIdxW-1:0];
                row_req_o   = '{en: 1'b1, we: 1'b1};
                row_wdata_o = {base, cnt + CntW'(1)};
                slot_d      = sum_app;
                cnt_d       = cnt + CntW'(1);
                state_d     = S_APP_MAP;
              end
            end
            srts_pkg::KIND_REMOVE: begin
              if (cnt == '0) begin
                done_d       = 1'b1;
                res_slot_d   = base;
                res_status_d = srts_pkg::ST_EMPTY;
                state_d      = S_IDLE;
              end else if (sum_last >= lim || !term_ok) begin
                done_d       = 1'b1;
                res_slot_d   = sum_last[SlotW-1:0];
                res_status_d = srts_pkg::ST_RANGE;
                state_d      = S_IDLE;
              end else begin
                // Look up the slot of the term being removed.
                term_en_o   = 1'b1;
                term_addr_o = term_idx;
                slot_d      = sum_last;
                cnt_d       = cnt;
                state_d     = S_RM_HOLE;
              end
            end
            srts_pkg::KIND_READ: begin
              res_slot_d = sum_rd[SlotW-1:0];
              if (sum_rd >= lim) begin
                done_d       = 1'b1;
                res_status_d = srts_pkg::ST_RANGE;
                state_d      = S_IDLE;
              end else begin
                term_en_o   = 1'b1;
                term_addr_o = sum_rd[TermIdxW-1:0];
                state_d     = S_READ;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      // Append: point the forward map at the new slot.
      S_APP_MAP: begin
        term_en_o   = 1'b1;
        term_we_o   = '{coef: 1'b0, col: 1'b0, s2t: 1'b0, t2s: 1'b1};
        term_addr_o = term_idx;
        term_t2s_o  = slot_q[TermIdxW-1:0];
        done_d      = 1'b1;
        res_cnt_d   = cnt_out(cnt_q);
        state_d     = S_IDLE;
      end

      // Removal: take the hole slot and read the row's last entry.
      S_RM_HOLE: begin
        hole_d      = term_t2s_i;
        term_en_o   = 1'b1;
        term_addr_o = slot_q[TermIdxW-1:0];
        state_d     = S_RM_LAST;
      end

      // Removal: move the last entry into the hole and drop the count, unless a looked-up slot is out of range.
      S_RM_LAST: begin
        res_slot_d = slot_q[SlotW-1:0];
        if (SumW'(hole_q) >= lim || SumW'(term_s2t_i) >= lim) begin
          done_d       = 1'b1;
          res_cnt_d    = cnt_out(cnt_q);
          res_status_d = srts_pkg::ST_RANGE;
          state_d      = S_IDLE;
        end else begin
          term_en_o   = 1'b1;
          term_we_o   = '{coef: 1'b1, col: 1'b1, s2t: 1'b1, t2s: 1'b0};
          term_addr_o = hole_q;
          term_coef_o = term_coef_i;
          term_col_o  = term_col_i;
          term_s2t_o  = term_s2t_i;
          row_req_o   = '{en: 1'b1, we: 1'b1};
          row_wdata_o = {base, cnt_q - CntW'(1)};
          cnt_d       = cnt_q - CntW'(1);
          mv_d        = term_s2t_i;
          state_d     = S_RM_MAP;
        end
      end

      // Removal: point the moved term's forward map at the hole.
      S_RM_MAP: begin
        term_en_o   = 1'b1;
        term_we_o   = '{coef: 1'b0, col: 1'b0, s2t: 1'b0, t2s: 1'b1};
        term_addr_o = mv_q;
        term_t2s_o  = hole_q;
        done_d      = 1'b1;
        res_cnt_d   = cnt_out(cnt_q);
        res_moved_d = term_out(mv_q);
        state_d     = S_IDLE;
      end

      // Read: the entry is available.
      S_READ: begin
        done_d     = 1'b1;
        res_coef_d = srts_pkg::CoefPortW'(term_coef_i);
        res_col_d  = term_col_i;
        state_d    = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State, command capture and registered results.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      kind_q       <= srts_pkg::KIND_SET_START;
      row_ok_q     <= 1'b0;
      row_q        <= '0;
      start_q      <= '0;
      term_q       <= '0;
      coef_q       <= '0;
      col_q        <= '0;
      pos_q        <= '0;
      slot_q       <= '0;
      cnt_q        <= '0;
      hole_q       <= '0;
      mv_q         <= '0;
      done_q       <= 1'b0;
      res_slot_q   <= '0;
      res_cnt_q    <= '0;
      res_moved_q  <= '0;
      res_coef_q   <= '0;
      res_col_q    <= '0;
      res_status_q <= srts_pkg::ST_OK;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      kind_q       <= kind_d;
      row_ok_q     <= row_ok_d;
      row_q        <= row_d;
      start_q      <= start_d;
      term_q       <= term_d;
      coef_q       <= coef_d;
      col_q        <= col_d;
      pos_q        <= pos_d;
      slot_q       <= slot_d;
      cnt_q        <= cnt_d;
      hole_q       <= hole_d;
      mv_q         <= mv_d;
      done_q       <= done_d;
      res_slot_q   <= res_slot_d;
      res_cnt_q    <= res_cnt_d;
      res_moved_q  <= res_moved_d;
      res_coef_q   <= res_coef_d;
      res_col_q    <= res_col_d;
      res_status_q <= res_status_d;
    end
  end

  assign busy_o            = (state_q != S_IDLE);
  assign done_o            = done_q;
  assign slot_o            = res_slot_q;
  assign row_count_after_o = res_cnt_q;
  assign moved_term_o      = res_moved_q;
  assign coefficient_out_o = res_coef_q;
  assign column_out_o      = res_col_q;
  assign status_o          = res_status_q;

endmodule

[verif/tb_top.sv]
// Self-checking testbench for the sparse row term store unit.
module tb_top;
  import srts_pkg::*;

  localparam int unsigned MAX_ROWS    = 1024;
  localparam int unsigned MAX_TERMS   = 4096;
  localparam int unsigned COEF_BITS   = 64;
  localparam logic [CoefPortW-1:0] COEF_MASK = {CoefPortW{1'b1}} >> (CoefPortW - COEF_BITS);
  localparam int unsigned RANDOM_CMDS = 1400;
  localparam int unsigned CYCLE_LIMIT = 100000;

  // One command as it crosses the command ports.
  typedef struct packed {
    kind_e                 kind;
    logic [RowPortW-1:0]   row;
    logic [SlotW-1:0]      row_start;
    logic [TermPortW-1:0]  term_index;
    logic [CoefPortW-1:0]  coefficient;
    logic [ColW-1:0]       column;
    logic [SlotW-1:0]      position;
  } term_cmd_t;

  // One result as it appears on the result ports.
  typedef struct packed {
    logic [SlotW-1:0]      slot;
    logic [CountPortW-1:0] count_after;
    logic [TermPortW-1:0]  moved;
    logic [CoefPortW-1:0]  coef;
    logic [ColW-1:0]       col;
    status_e               status;
  } term_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start_i = 1'b0;
  logic                  busy_o;
  logic [1:0]            kind_i = '0;
  logic [RowPortW-1:0]   row_i = '0;
  logic [SlotW-1:0]      row_start_i = '0;
  logic [TermPortW-1:0]  term_index_i = '0;
  logic [CoefPortW-1:0]  coefficient_i = '0;
  logic [ColW-1:0]       column_i = '0;
  logic [SlotW-1:0]      position_i = '0;
  logic                  done_o;
  logic [SlotW-1:0]      slot_o;
  logic [CountPortW-1:0] row_count_after_o;
  logic [TermPortW-1:0]  moved_term_o;
  logic [CoefPortW-1:0]  coefficient_out_o;
  logic [ColW-1:0]       column_out_o;
  logic [1:0]            status_o;

  sparse_row_term_store_unit #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_TERMS(MAX_TERMS),
    .COEF_BITS(COEF_BITS)
  ) DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .kind_i           (kind_i),
    .row_i            (row_i),
    .row_start_i      (row_start_i),
    .term_index_i     (term_index_i),
    .coefficient_i    (coefficient_i),
    .column_i         (column_i),
    .position_i       (position_i),
    .done_o           (done_o),
    .slot_o           (slot_o),
    .row_count_after_o(row_count_after_o),
    .moved_term_o     (moved_term_o),
    .coefficient_out_o(coefficient_out_o),
    .column_out_o     (column_out_o),
    .status_o         (status_o)
  );

  // Shadow copy of the store, plus marks of which entries hold written data.
  bit [SlotW-1:0]      base_of_row  [MAX_ROWS];
  bit [CountPortW-1:0] count_of_row [MAX_ROWS];
  bit [CoefPortW-1:0]  coef_mem     [MAX_TERMS];
  bit [ColW-1:0]       col_mem      [MAX_TERMS];
  bit [SlotW-1:0]      slot_of_term [MAX_TERMS];
  bit [TermPortW-1:0]  term_in_slot [MAX_TERMS];
  bit                  row_set      [MAX_ROWS];
  bit                  slot_filled  [MAX_TERMS];
  bit                  term_mapped  [MAX_TERMS];

  term_cmd_t    cmd_fifo[$];
  term_result_t due_results[$];
  term_cmd_t    active_cmd;
  int unsigned  cmds_issued = 0;
  int unsigned  cmds_driven = 0;
  int unsigned  cmds_accepted = 0;
  int unsigned  burst_left = 0;
  int unsigned  gap_left = 0;
  int unsigned  fail_count = 0;
  int unsigned  cycle_count = 0;
  int unsigned  kind_count[4];
  int unsigned  status_count[4];

  // Applies one command to the shadow store and returns the result it must give.
  function automatic term_result_t apply_store_cmd(input term_cmd_t c);
    term_result_t r;
    int unsigned  base;
    int unsigned  cnt;
    int unsigned  at;
    int unsigned  last;
    int unsigned  hole;
    int unsigned  mover;
    r = '0;
    r.status = ST_OK;
    base = base_of_row[c.row];
    cnt = count_of_row[c.row];
    at = 0;
    case (c.kind)
      KIND_SET_START: begin
        base_of_row[c.row] = c.row_start;
        count_of_row[c.row] = '0;
        row_set[c.row] = 1'b1;
        at = c.row_start;
        cnt = 0;
      end
      KIND_APPEND: begin
        at = base + cnt;
        if (at >= MAX_TERMS || c.term_index >= MAX_TERMS) begin
          r.status = ST_RANGE;
        end else begin
          coef_mem[at] = c.coefficient & COEF_MASK;
          col_mem[at] = c.column;
          slot_of_term[c.term_index] = SlotW'(at);
          term_in_slot[at] = c.term_index;
          slot_filled[at] = 1'b1;
          term_mapped[c.term_index] = 1'b1;
          cnt++;
          count_of_row[c.row] = CountPortW'(cnt);
        end
      end
      KIND_REMOVE: begin
        if (cnt == 0) begin
          r.status = ST_EMPTY;
          at = base;
        end else begin
          last = base + cnt - 1;
          at = last;
          if (c.term_index >= MAX_TERMS || last >= MAX_TERMS) begin
            r.status = ST_RANGE;
          end else begin
            hole = slot_of_term[c.term_index];
            mover = term_in_slot[last];
            if (hole >= MAX_TERMS || mover >= MAX_TERMS) begin
              r.status = ST_RANGE;
            end else begin
              // The row's last term fills the hole left by the removed one.
              coef_mem[hole] = coef_mem[last];
              col_mem[hole] = col_mem[last];
              slot_of_term[mover] = SlotW'(hole);
              term_in_slot[hole] = TermPortW'(mover);
              cnt--;
              count_of_row[c.row] = CountPortW'(cnt);
              r.moved = TermPortW'(mover);
            end
          end
        end
      end
      default: begin
        at = base + c.position;
        if (at >= MAX_TERMS) begin
          r.status = ST_RANGE;
        end else begin
          r.coef = coef_mem[at];
          r.col = col_mem[at];
        end
      end
    endcase
    r.slot = SlotW'(at);
    r.count_after = CountPortW'(cnt);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  // Hands one command to the driver and waits for its transfer, so that the
  // next command can be chosen from the store as it then stands.
  task automatic send_cmd(input term_cmd_t c);
    cmd_fifo.push_back(c);
    cmds_issued++;
    wait (cmds_accepted == cmds_issued);
  endtask

  // Builds a command of the wanted kind on a row, with random filler in the
  // fields it does not use. Never touches an entry that was never written.
  task automatic issue_op(input kind_e want_kind, input int unsigned row, input bit aimed);
    term_cmd_t   c;
    int unsigned base;
    int unsigned cnt;
    int unsigned tries;
    bit          found;
    c.kind = want_kind;
    c.row = RowPortW'(row);
    c.row_start = SlotW'($urandom);
    c.term_index = TermPortW'($urandom);
    c.coefficient = {$urandom, $urandom};
    c.column = ColW'($urandom);
    c.position = SlotW'($urandom);
    base = base_of_row[row];
    cnt = count_of_row[row];
    if (want_kind != KIND_SET_START && !row_set[row]) c.kind = KIND_SET_START;
    case (c.kind)
      KIND_SET_START: begin
        if (aimed) begin
          c.row_start = ($urandom_range(0, 4) == 0) ? SlotW'($urandom_range(4080, 4095))
                                                     : SlotW'($urandom_range(0, 3900));
        end
      end
      KIND_REMOVE: begin
        if (cnt > 0) begin
          found = 1'b0;
          if (!aimed) begin
            for (tries = 0; tries < 8 && !found; tries++) begin
              c.term_index = TermPortW'($urandom);
              found = term_mapped[c.term_index];
            end
          end
          if (!found) c.term_index = term_in_slot[base + $urandom_range(0, cnt - 1)];
        end
      end
      KIND_READ: begin
        found = 1'b0;
        if (aimed && cnt > 0 && $urandom_range(0, 3) != 0) begin
          c.position = SlotW'($urandom_range(0, cnt - 1));
          found = 1'b1;
        end
        for (tries = 0; tries < 8 && !found; tries++) begin
          c.position = SlotW'($urandom);
          found = (base + c.position >= MAX_TERMS) || slot_filled[base + c.position];
        end
        if (!found) c.kind = KIND_SET_START;
      end
      default: ;
    endcase
    send_cmd(c);
  endtask

  // Clock.
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Driver: presents commands at the falling edge, in bursts with gaps.
  always @(negedge clk_i) begin
    if (rst_ni && cmds_accepted == cmds_driven) begin
      if (gap_left > 0) begin
        gap_left--;
        start_i <= 1'b0;
      end else if (cmd_fifo.size() > 0) begin
        active_cmd = cmd_fifo.pop_front();
        cmds_driven++;
        kind_i <= active_cmd.kind;
        row_i <= active_cmd.row;
        row_start_i <= active_cmd.row_start;
        term_index_i <= active_cmd.term_index;
        coefficient_i <= active_cmd.coefficient;
        column_i <= active_cmd.column;
        position_i <= active_cmd.position;
        start_i <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 30);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
        end
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // A command transfer updates the shadow store and queues its result.
  always @(posedge clk_i) begin
    if (rst_ni && start_i && !busy_o) begin
      due_results.push_back(apply_store_cmd(active_cmd));
      kind_count[active_cmd.kind]++;
      cmds_accepted++;
    end
  end

  // Monitor: every strobed result is checked against the oldest one due.
  always @(posedge clk_i) begin
    term_result_t want;
    if (rst_ni && done_o) begin
      if (due_results.size() == 0) begin
        $error("result with none due: slot 0x%0h status %0d", slot_o, status_o);
        fail_count++;
      end else begin
        want = due_results.pop_front();
        check_field("slot", want.slot, slot_o);
        check_field("row_count_after", want.count_after, row_count_after_o);
        check_field("moved_term", want.moved, moved_term_o);
        check_field("coefficient_out", want.coef, coefficient_out_o);
        check_field("column_out", want.col, column_out_o);
        check_field("status", want.status, status_o);
        status_count[status_o]++;
      end
    end
  end

  // Watchdog on the cycle count.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Run timed out after %0d cycles.", cycle_count);
    $display("FAIL sparse_row_term_store_unit");
    $finish;
  end

  // Stimulus and end of run.
  initial begin : stimulus
    int unsigned hot_rows[8];
    int unsigned row;
    int unsigned run;
    int unsigned pick;
    int unsigned directed_cmds;
    int unsigned k;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: field extremes, removal of first and last terms, empty row,
    // append and read past the end of the store, read past the live count.
    send_cmd('{KIND_SET_START, 10'd0, 12'd0, 12'd0, 64'd0, 12'd0, 12'd0});
    send_cmd('{KIND_APPEND, 10'd0, 12'd0, 12'd0, '1, 12'd4095, 12'd0});
    send_cmd('{KIND_APPEND, 10'd0, 12'd0, 12'd4095, 64'd0, 12'd0, 12'd0});
    send_cmd('{KIND_APPEND, 10'd0, 12'd0, 12'd7, 64'h8000_0000_0000_0001, 12'd2048, 12'd0});
    send_cmd('{KIND_READ, 10'd0, 12'd0, 12'd0, 64'd0, 12'd0, 12'd0});
    send_cmd('{KIND_READ, 10'd0, 12'd0, 12'd0, 64'd0, 12'd0, 12'd2});
    send_cmd('{KIND_REMOVE, 10'd0, 12'd0, 12'd0, 64'd0, 12'd0, 12'd0});
    send_cmd('{KIND_REMOVE, 10'd0, 12'd0, 12'd4095, 64'd0, 12'd0, 12'd0});
    send_cmd('{KIND_REMOVE, 10'd0, 12'd0, 12'd7, 64'd0, 12'd0, 12'd0});
    send_cmd('{KIND_REMOVE, 10'd0, 12'd0, 12'd7, 64'd0, 12'd0, 12'd0});
    send_cmd('{KIND_READ, 10'd0, 12'd0, 12'd0, 64'd0, 12'd0, 12'd2});
    send_cmd('{KIND_SET_START, 10'd1023, 12'd4095, 12'd0, 64'd0, 12'd0, 12'd0});
    send_cmd('{KIND_APPEND, 10'd1023, 12'd0, 12'd100, 64'h0123_4567_89ab_cdef, 12'd1, 12'd0});
    send_cmd('{KIND_APPEND, 10'd1023, 12'd0, 12'd101, 64'hffff_0000_ffff_0000, 12'd2, 12'd0});
    send_cmd('{KIND_READ, 10'd1023, 12'd0, 12'd0, 64'd0, 12'd0, 12'd0});
    send_cmd('{KIND_READ, 10'd1023, 12'd0, 12'd0, 64'd0, 12'd0, 12'd4095});
    send_cmd('{KIND_READ, 10'd0, 12'd0, 12'd0, 64'd0, 12'd0, 12'd4095});
    send_cmd('{KIND_REMOVE, 10'd1023, 12'd0, 12'd100, 64'd0, 12'd0, 12'd0});
    send_cmd('{KIND_SET_START, 10'd512, 12'd2000, 12'd0, 64'd0, 12'd0, 12'd0});
    send_cmd('{KIND_APPEND, 10'd512, 12'd0, 12'd4095, 64'h5555_aaaa_5555_aaaa, 12'd3, 12'd0});
    send_cmd('{KIND_SET_START, 10'd512, 12'd2000, 12'd0, 64'd0, 12'd0, 12'd0});
    send_cmd('{KIND_REMOVE, 10'd512, 12'd0, 12'd4095, 64'd0, 12'd0, 12'd0});
    directed_cmds = cmds_issued;

    // Random: mostly runs of appends, reads and removals on a few busy rows,
    // mixed with stray commands on any row.
    for (int h = 0; h < 8; h++) hot_rows[h] = $urandom_range(0, MAX_ROWS - 1);
    while (cmds_issued < directed_cmds + RANDOM_CMDS) begin
      if ($urandom_range(0, 9) < 7) begin
        row = ($urandom_range(0, 4) == 0) ? $urandom_range(0, MAX_ROWS - 1)
                                           : hot_rows[$urandom_range(0, 7)];
        if (!row_set[row] || $urandom_range(0, 5) == 0) issue_op(KIND_SET_START, row, 1'b1);
        run = $urandom_range(2, 14);
        repeat (run) begin
          pick = $urandom_range(0, 99);
          issue_op(pick < 45 ? KIND_APPEND : (pick < 70 ? KIND_READ : KIND_REMOVE), row, 1'b1);
        end
      end else begin
        issue_op(kind_e'($urandom_range(0, 3)), $urandom_range(0, MAX_ROWS - 1), 1'b0);
      end
      if ($urandom_range(0, 19) == 0) hot_rows[$urandom_range(0, 7)] = $urandom_range(0, MAX_ROWS - 1);
    end

    // Drain the results still due, then allow for a stray late one.
    for (k = 0; k < 300 && due_results.size() > 0; k++) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (due_results.size() > 0) begin
      $error("%0d results never arrived", due_results.size());
      fail_count++;
    end

    $display("Commands: %0d set start, %0d append, %0d remove, %0d read.",
             kind_count[KIND_SET_START], kind_count[KIND_APPEND],
             kind_count[KIND_REMOVE], kind_count[KIND_READ]);
    $display("Results: %0d ok, %0d out of range, %0d empty row; %0d mismatches.",
             status_count[ST_OK], status_count[ST_RANGE], status_count[ST_EMPTY], fail_count);
    if (fail_count == 0) begin
      $display("PASS sparse_row_term_store_unit");
    end else begin
      $display("FAIL sparse_row_term_store_unit");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/srts_pkg.sv
rtl/core/srts_row_mem.sv
rtl/core/srts_term_mem.sv
rtl/core/srts_ctrl.sv
rtl/core/sparse_row_term_store_unit.sv
verif/tb_top.sv
